// ----- hdl/mtep_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, constants and helper functions for the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // Default limit on the length of a variable-length quantity, in bytes.
    localparam int MAX_VLQ_BYTES_DEF = 4;

    // Field widths.
    localparam int VLQ_W  = 28;
    localparam int BYTE_W = 8;

    // Record kinds.
    localparam logic [2:0] KIND_CHANNEL = 3'd0;
    localparam logic [2:0] KIND_SYSEX   = 3'd1;
    localparam logic [2:0] KIND_META    = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_VLQ_LONG = 2'd1;
    localparam logic [1:0] ERR_STATUS   = 2'd2;

    // Status bytes and masks.
    localparam logic [7:0] ST_SYSEX      = 8'hf0;
    localparam logic [7:0] ST_SYSEX_CONT = 8'hf7;
    localparam logic [7:0] ST_META       = 8'hff;
    localparam logic [7:0] META_EOT      = 8'h2f;
    localparam logic [7:0] MASK_HIGH     = 8'hf0;
    localparam logic [7:0] MASK_LOW      = 8'h0f;
    localparam logic [7:0] MASK_DATA     = 8'h7f;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DELTA,
        PH_STATUS,
        PH_PARAM1,
        PH_PARAM2,
        PH_METATYPE,
        PH_LENGTH,
        PH_PAYLOAD
    } phase_t;

    // Parser state carried from byte to byte (the VLQ byte count is kept apart,
    // as its width follows the VLQ length limit).
    typedef struct packed {
        phase_t               phase;
        logic [VLQ_W-1:0]     vlq_accum;
        logic [BYTE_W-1:0]    running_status;
        logic [BYTE_W-1:0]    current_status;
        logic [VLQ_W-1:0]     held_delta;
        logic [BYTE_W-1:0]    held_param;
        logic [BYTE_W-1:0]    held_meta_kind;
        logic [VLQ_W-1:0]     bytes_left;
    } parse_state_t;

    // One result record.
    typedef struct packed {
        logic [2:0]           record_kind;
        logic [VLQ_W-1:0]     delta_ticks;
        logic [BYTE_W-1:0]    event_status;
        logic [3:0]           channel;
        logic [BYTE_W-1:0]    param_one;
        logic [BYTE_W-1:0]    param_two;
        logic [BYTE_W-1:0]    meta_kind;
        logic [VLQ_W-1:0]     payload_length;
        logic [BYTE_W-1:0]    payload_byte;
        logic                 last;
        logic                 end_of_track;
        logic [1:0]           error_code;
    } record_t;

    // Channel status bytes 0x80 to 0xEF.
    function automatic logic is_chan_status(input logic [7:0] s);
        is_chan_status = s[7] && (s[6:4] != 3'b111);
    endfunction

    // Note off, note on, key pressure, controller and pitch bend take two
    // parameters.
    function automatic logic has_two_params(input logic [7:0] s);
        logic [7:0] n;
        n = s & MASK_HIGH;
        has_two_params = (n == 8'h80) || (n == 8'h90) || (n == 8'ha0) ||
                         (n == 8'hb0) || (n == 8'he0);
    endfunction

endpackage

// ----- hdl/midi_track_event_parser_top.sv -----
// Output: a result record appears on the master side in the cycle after the
// transfer of the byte that completes it.
// Throughput: one track byte per cycle, sustained; a waiting result does not
// stop the next byte unless the result register is full and not being taken.
// Reset: the parser returns to idle and ignores bytes until one arrives with
// the track start flag set; the result register is emptied.
// ----------------------------------------------------------------------------
// MIDI track event parser
// Decodes the event body of a standard MIDI file track, one byte a transfer,
// into channel event, sysex, meta, payload byte and error records.
// ----------------------------------------------------------------------------
module midi_track_event_parser_top #(
    parameter int MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // Input byte stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] track_start
    // Result records.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [27:0] delta_ticks, [35:28] event_status, [39:36] channel,
    // [47:40] param_one, [55:48] param_two, [63:56] meta_kind,
    // [91:64] payload_length, [99:92] payload_byte, [103:100] zero
    output logic [103:0] m_tdata,
    // [2:0] record_kind, [3] end_of_track, [5:4] error_code
    output logic [5:0]   m_tuser,
    output logic         m_tlast    // last record of an event
);

    localparam int CNT_W = (MAX_VLQ_BYTES > 1) ? $clog2(MAX_VLQ_BYTES) : 1;

    mtep_pkg::parse_state_t state_reg;
    mtep_pkg::parse_state_t state_next;
    logic [CNT_W-1:0]       vlq_count_reg;
    logic [CNT_W-1:0]       vlq_count_next;
    logic                   rec_valid;
    mtep_pkg::record_t      rec;
    mtep_pkg::record_t      out_reg;
    logic                   out_valid_reg;
    logic                   in_xfer;

    // A byte is taken whenever the result register is free or being emptied.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    mtep_step #(
        .MAX_VLQ_BYTES (MAX_VLQ_BYTES),
        .CNT_W         (CNT_W)
    ) u_step (
        .state_cur      (state_reg),
        .vlq_count_cur  (vlq_count_reg),
        .data_byte      (s_tdata),
        .track_start    (s_tuser),
        .state_next     (state_next),
        .vlq_count_next (vlq_count_next),
        .rec_valid      (rec_valid),
        .rec            (rec)
    );

    // Parser state advances on every input transfer. The all-zero state is
    // the idle phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            vlq_count_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg     <= state_next;
            vlq_count_reg <= vlq_count_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer && rec_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer && rec_valid)
        begin
            out_reg <= rec;
        end
    end

    // Pack the record onto the master side.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_reg.payload_byte,
                       out_reg.payload_length,
                       out_reg.meta_kind,
                       out_reg.param_two,
                       out_reg.param_one,
                       out_reg.channel,
                       out_reg.event_status,
                       out_reg.delta_ticks};
    assign m_tuser  = {out_reg.error_code, out_reg.end_of_track, out_reg.record_kind};
    assign m_tlast  = out_reg.last;

endmodule

// ----- hdl/mtep_step.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser step logic
// Combinational decode of one track byte against the current parser state:
// next state and at most one result record.
// ----------------------------------------------------------------------------
module mtep_step #(
    parameter int MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES_DEF,
    parameter int CNT_W         = (MAX_VLQ_BYTES > 1) ? $clog2(MAX_VLQ_BYTES) : 1
) (
    input  mtep_pkg::parse_state_t state_cur,
    input  logic [CNT_W-1:0]       vlq_count_cur,
    input  logic [7:0]             data_byte,
    input  logic                   track_start,
    output mtep_pkg::parse_state_t state_next,
    output logic [CNT_W-1:0]       vlq_count_next,
    output logic                   rec_valid,
    output mtep_pkg::record_t      rec
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_VLQ_BYTES - 1);

    mtep_pkg::parse_state_t st;
    logic [CNT_W-1:0]       cnt;
    logic [27:0]            acc_new;
    logic                   more;
    logic                   too_long;
    logic                   is_meta;
    logic                   eot;
    logic                   fin;

    always_comb
    begin
        // A track start clears everything before the byte is used.
        st  = state_cur;
        cnt = vlq_count_cur;
        if (track_start)
        begin
            st       = '0;
            st.phase = mtep_pkg::PH_DELTA;
            cnt      = '0;
        end

        state_next     = st;
        vlq_count_next = cnt;
        rec_valid      = 1'b0;
        rec            = '0;

        acc_new  = {st.vlq_accum[20:0], data_byte[6:0]};
        more     = data_byte[7];
        too_long = (cnt >= CNT_LAST);
        is_meta  = (st.current_status == mtep_pkg::ST_META);
        eot      = is_meta && (st.held_meta_kind == mtep_pkg::META_EOT);
        fin      = (st.bytes_left <= 28'd1);

        case (st.phase)
            // Delta time, seven bits a byte.
            mtep_pkg::PH_DELTA:
            begin
                state_next.vlq_accum = acc_new;
                if (!more)
                begin
                    state_next.held_delta = acc_new;
                    state_next.vlq_accum  = '0;
                    vlq_count_next        = '0;
                    state_next.phase      = mtep_pkg::PH_STATUS;
                end
                else if (too_long)
                begin
                    rec_valid        = 1'b1;
                    rec.record_kind  = mtep_pkg::KIND_ERROR;
                    rec.last         = 1'b1;
                    rec.error_code   = mtep_pkg::ERR_VLQ_LONG;
                    state_next.phase = mtep_pkg::PH_IDLE;
                end
                else
                begin
                    vlq_count_next = cnt + 1'b1;
                end
            end

            // Status byte, or a data byte under running status.
            mtep_pkg::PH_STATUS:
            begin
                if (!data_byte[7])
                begin
                    if (!mtep_pkg::is_chan_status(st.running_status))
                    begin
                        rec_valid        = 1'b1;
                        rec.record_kind  = mtep_pkg::KIND_ERROR;
                        rec.event_status = st.running_status;
                        rec.last         = 1'b1;
                        rec.error_code   = mtep_pkg::ERR_STATUS;
                        state_next.phase = mtep_pkg::PH_IDLE;
                    end
                    else
                    begin
                        state_next.current_status = st.running_status;
                        if (mtep_pkg::has_two_params(st.running_status))
                        begin
                            state_next.held_param = data_byte;
                            state_next.phase      = mtep_pkg::PH_PARAM2;
                        end
                        else
                        begin
                            rec_valid        = 1'b1;
                            rec.record_kind  = mtep_pkg::KIND_CHANNEL;
                            rec.delta_ticks  = st.held_delta;
                            rec.event_status = st.running_status & mtep_pkg::MASK_HIGH;
                            rec.channel      = st.running_status[3:0];
                            rec.param_one    = data_byte;
                            rec.last         = 1'b1;
                            state_next.phase = mtep_pkg::PH_DELTA;
                        end
                    end
                end
                else if (mtep_pkg::is_chan_status(data_byte))
                begin
                    state_next.running_status = data_byte;
                    state_next.current_status = data_byte;
                    state_next.phase          = mtep_pkg::PH_PARAM1;
                end
                else if ((data_byte == mtep_pkg::ST_SYSEX) ||
                         (data_byte == mtep_pkg::ST_SYSEX_CONT))
                begin
                    state_next.running_status = '0;
                    state_next.current_status = data_byte;
                    state_next.held_meta_kind = '0;
                    state_next.vlq_accum      = '0;
                    vlq_count_next            = '0;
                    state_next.phase          = mtep_pkg::PH_LENGTH;
                end
                else if (data_byte == mtep_pkg::ST_META)
                begin
                    state_next.running_status = '0;
                    state_next.current_status = data_byte;
                    state_next.phase          = mtep_pkg::PH_METATYPE;
                end
                else
                begin
                    rec_valid        = 1'b1;
                    rec.record_kind  = mtep_pkg::KIND_ERROR;
                    rec.event_status = data_byte;
                    rec.last         = 1'b1;
                    rec.error_code   = mtep_pkg::ERR_STATUS;
                    state_next.phase = mtep_pkg::PH_IDLE;
                end
            end

            // First parameter after an explicit status.
            mtep_pkg::PH_PARAM1:
            begin
                if (mtep_pkg::has_two_params(st.current_status))
                begin
                    state_next.held_param = data_byte;
                    state_next.phase      = mtep_pkg::PH_PARAM2;
                end
                else
                begin
                    rec_valid        = 1'b1;
                    rec.record_kind  = mtep_pkg::KIND_CHANNEL;
                    rec.delta_ticks  = st.held_delta;
                    rec.event_status = st.current_status & mtep_pkg::MASK_HIGH;
                    rec.channel      = st.current_status[3:0];
                    rec.param_one    = data_byte;
                    rec.last         = 1'b1;
                    state_next.phase = mtep_pkg::PH_DELTA;
                end
            end

            // Second parameter completes the channel event.
            mtep_pkg::PH_PARAM2:
            begin
                rec_valid        = 1'b1;
                rec.record_kind  = mtep_pkg::KIND_CHANNEL;
                rec.delta_ticks  = st.held_delta;
                rec.event_status = st.current_status & mtep_pkg::MASK_HIGH;
                rec.channel      = st.current_status[3:0];
                rec.param_one    = st.held_param;
                rec.param_two    = data_byte;
                rec.last         = 1'b1;
                state_next.phase = mtep_pkg::PH_DELTA;
            end

            // Meta event type byte.
            mtep_pkg::PH_METATYPE:
            begin
                state_next.held_meta_kind = data_byte;
                state_next.vlq_accum      = '0;
                vlq_count_next            = '0;
                state_next.phase          = mtep_pkg::PH_LENGTH;
            end

            // Payload length; its last byte gives the start record.
            mtep_pkg::PH_LENGTH:
            begin
                state_next.vlq_accum = acc_new;
                if (!more)
                begin
                    state_next.bytes_left = acc_new;
                    state_next.vlq_accum  = '0;
                    vlq_count_next        = '0;
                    rec_valid             = 1'b1;
                    rec.record_kind       = is_meta ? mtep_pkg::KIND_META
                                                    : mtep_pkg::KIND_SYSEX;
                    rec.delta_ticks       = st.held_delta;
                    rec.event_status      = st.current_status;
                    rec.meta_kind         = is_meta ? st.held_meta_kind : '0;
                    rec.payload_length    = acc_new;
                    if (acc_new == '0)
                    begin
                        rec.last         = 1'b1;
                        rec.end_of_track = eot;
                        state_next.phase = eot ? mtep_pkg::PH_IDLE : mtep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        state_next.phase = mtep_pkg::PH_PAYLOAD;
                    end
                end
                else if (too_long)
                begin
                    rec_valid        = 1'b1;
                    rec.record_kind  = mtep_pkg::KIND_ERROR;
                    rec.last         = 1'b1;
                    rec.error_code   = mtep_pkg::ERR_VLQ_LONG;
                    state_next.phase = mtep_pkg::PH_IDLE;
                end
                else
                begin
                    vlq_count_next = cnt + 1'b1;
                end
            end

            // One record for each payload byte.
            mtep_pkg::PH_PAYLOAD:
            begin
                rec_valid             = 1'b1;
                rec.record_kind       = mtep_pkg::KIND_PAYLOAD;
                rec.delta_ticks       = st.held_delta;
                rec.event_status      = st.current_status;
                rec.meta_kind         = is_meta ? st.held_meta_kind : '0;
                rec.payload_byte      = data_byte;
                state_next.bytes_left = fin ? '0 : st.bytes_left - 28'd1;
                if (fin)
                begin
                    rec.last         = 1'b1;
                    rec.end_of_track = eot;
                    state_next.phase = eot ? mtep_pkg::PH_IDLE : mtep_pkg::PH_DELTA;
                end
            end

            default:
            begin
                state_next.phase = mtep_pkg::PH_IDLE;
            end
        endcase
    end

endmodule
